@@ rtl/core/lcyt_pkg.sv @@
// ----------------------------------------------------------------------------
// lcyt_pkg
// Types, constants and helpers shared by the yaw tracker modules.
// ----------------------------------------------------------------------------
package lcyt_pkg;

  typedef struct packed {
    logic        [31:0] time_ms;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] follower_x;
    logic signed [31:0] follower_y;
  } in_t;

  typedef struct packed {
    logic signed [15:0] turn_rate;
    logic        [31:0] travelled_distance;
    logic               degenerate;
  } out_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_MAG, ST_HALF,
    ST_T_SQ1, ST_T_SQ2, ST_T_SUM, ST_T_ROOT,
    ST_A_SQ1, ST_A_SQ2, ST_A_SUM, ST_A_ROOT,
    ST_B_SQ1, ST_B_SQ2, ST_B_SUM, ST_B_ROOT,
    ST_N_P1, ST_N_P2, ST_N_P3, ST_N_COMB, ST_N_DEC,
    ST_DIV_WAIT, ST_SINE_MUL, ST_SINE_SUB, ST_SINE_ROOT,
    ST_CORD_WAIT, ST_POST, ST_FINISH
  } state_t;

  localparam logic [2:0]  REG_UPDATE_PERIOD   = 3'd0;
  localparam logic [15:0] UPDATE_PERIOD_RESET = 16'd1000;
  localparam logic [30:0] RATIO_ONE           = 31'h4000_0000;
  localparam logic [65:0] RATIO_ONE_SQ        = 66'h1_0000_0000_0000_000;
  localparam logic [31:0] PI_Q30              = 32'd3373259426;
  localparam logic [15:0] YAW_MAX             = 16'd25736;
  localparam logic [31:0] HALF_LIMIT          = 32'h8000_0000;

  localparam logic [29:0] ATAN_Q30 [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  // Magnitude of a 33-bit signed difference; it always fits in 32 bits.
  function automatic logic [31:0] mag33(input logic signed [32:0] d);
    logic [32:0] n;
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

endpackage

@@ rtl/core/law_of_cosines_yaw_tracker.sv @@
// ----------------------------------------------------------------------------
// law_of_cosines_yaw_tracker
// Turn angle of a moving target seen from a follower, by the law of cosines.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall with a timestamp, a target and a
// follower position. The first request after reset only stores the target.
// A later request whose timestamp is at least update_period_ms past the last
// update yields one result on out_valid/out_stall: turn_rate, target travel
// and the degenerate flag. Other requests yield nothing.
// One request is processed at a time; in_stall is high while it is in work.
// A request that yields a result loads it into the output register from the
// finish state, which waits while the output is stalled, and then returns to
// idle to take the next request. A ratio of magnitude one skips the divide.
// The work runs through four passes of the 33-step square root unit, the
// 30-step divider and the CORDIC loop. Degenerate geometry skips the angle
// and gives its result right after the root of the target travel.
// The result sits in an output register; a stalled receiver only delays the
// next result, and the next request is taken meanwhile. Reset clears the
// stored position and time and sets the period register to 1000 ms.
// ----------------------------------------------------------------------------
module law_of_cosines_yaw_tracker #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lcyt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lcyt_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import lcyt_pkg::*;

  state_t state;
  state_t state_next;

  in_t                req;
  logic [15:0]        period;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic [31:0]        last_time;
  logic               initialized;

  logic signed [32:0] dtx, dty, ax, ay, bx, by;
  logic [31:0]        mtx, mty, m0, m1, m2, m3;
  logic               neg0, neg1, neg2, neg3;
  logic               big, degen, fwd, yaw_zero;
  logic [63:0]        acc, p1, p2, num, den;
  logic               num_neg;
  logic [31:0]        travel, len_a, len_b, zpost;
  logic [30:0]        ratio;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic               sq_start;
  logic [65:0]        sq_op;
  logic [32:0]        sq_root;
  logic               sq_done;
  logic               div_start;
  logic [29:0]        div_q;
  logic               div_done;
  logic               cord_start;
  logic signed [33:0] cord_z;
  logic               cord_done;

  logic [31:0]        elapsed;
  logic [32:0]        rnd;
  logic [15:0]        ymag;
  logic [15:0]        yclamp;
  logic               out_free;

  lcyt_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  lcyt_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .op(sq_op),
    .root(sq_root), .done(sq_done)
  );

  lcyt_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
    .quo(div_q), .done(div_done)
  );

  // The sine goes straight from the root unit into the CORDIC at its start.
  lcyt_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic (
    .clk(clk), .rst(rst), .start(cord_start), .x0(ratio), .y0(sq_root[30:0]),
    .z(cord_z), .done(cord_done)
  );

  assign pready   = 1'b1;
  assign prdata   = {16'd0, period};
  assign in_stall = (state != ST_IDLE);
  assign elapsed  = req.time_ms - last_time;
  assign out_free = !(out_valid && out_stall);
  assign rnd      = {1'b0, zpost} + 33'h1_0000;
  assign ymag     = rnd[32:17];
  assign yclamp   = (ymag > YAW_MAX) ? YAW_MAX : ymag;

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= UPDATE_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_UPDATE_PERIOD[2]) begin
      period <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = mtx;
    mul_b      = mtx;
    sq_start   = 1'b0;
    // The sum of two squares can carry into bit 64.
    sq_op      = {1'b0, 65'(acc) + 65'(prod)};
    div_start  = 1'b0;
    cord_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (!initialized || elapsed < 32'(period)) state_next = ST_IDLE;
        else state_next = ST_MAG;
      end
      ST_MAG:    state_next = ST_HALF;
      ST_HALF:   state_next = ST_T_SQ1;
      ST_T_SQ1:  state_next = ST_T_SQ2;
      ST_T_SQ2: begin
        mul_a = mty;
        mul_b = mty;
        state_next = ST_T_SUM;
      end
      ST_T_SUM: begin
        sq_start = 1'b1;
        state_next = ST_T_ROOT;
      end
      ST_T_ROOT: begin
        if (sq_done) state_next = degen ? ST_FINISH : ST_A_SQ1;
      end
      ST_A_SQ1: begin
        mul_a = m0;
        mul_b = m0;
        state_next = ST_A_SQ2;
      end
      ST_A_SQ2: begin
        mul_a = m1;
        mul_b = m1;
        state_next = ST_A_SUM;
      end
      ST_A_SUM: begin
        sq_start = 1'b1;
        state_next = ST_A_ROOT;
      end
      ST_A_ROOT: begin
        if (sq_done) state_next = ST_B_SQ1;
      end
      ST_B_SQ1: begin
        mul_a = m2;
        mul_b = m2;
        state_next = ST_B_SQ2;
      end
      ST_B_SQ2: begin
        mul_a = m3;
        mul_b = m3;
        state_next = ST_B_SUM;
      end
      ST_B_SUM: begin
        sq_start = 1'b1;
        state_next = ST_B_ROOT;
      end
      ST_B_ROOT: begin
        if (sq_done) state_next = ST_N_P1;
      end
      ST_N_P1: begin
        mul_a = m0;
        mul_b = m2;
        state_next = ST_N_P2;
      end
      ST_N_P2: begin
        mul_a = m1;
        mul_b = m3;
        state_next = ST_N_P3;
      end
      ST_N_P3: begin
        mul_a = len_a;
        mul_b = len_b;
        state_next = ST_N_COMB;
      end
      ST_N_COMB: state_next = ST_N_DEC;
      ST_N_DEC: begin
        if (den == '0) begin
          state_next = ST_FINISH;
        end else if (num >= den) begin
          state_next = ST_SINE_MUL;
        end else begin
          div_start = 1'b1;
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) state_next = ST_SINE_MUL;
      end
      ST_SINE_MUL: begin
        mul_a = 32'(ratio);
        mul_b = 32'(ratio);
        state_next = ST_SINE_SUB;
      end
      ST_SINE_SUB: begin
        sq_start = 1'b1;
        sq_op = RATIO_ONE_SQ - {2'b00, prod};
        state_next = ST_SINE_ROOT;
      end
      ST_SINE_ROOT: begin
        if (sq_done) begin
          cord_start = 1'b1;
          state_next = ST_CORD_WAIT;
        end
      end
      ST_CORD_WAIT: begin
        if (cord_done) state_next = ST_POST;
      end
      ST_POST: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: stored target, time and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x      <= '0;
      prev_y      <= '0;
      last_time   <= '0;
      initialized <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (state == ST_CHECK && !initialized) begin
        prev_x      <= req.target_x;
        prev_y      <= req.target_y;
        initialized <= 1'b1;
      end
      if (state == ST_FINISH && out_free) begin
        prev_x    <= req.target_x;
        prev_y    <= req.target_y;
        last_time <= req.time_ms;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) req <= in_data;
      end
      ST_CHECK: begin
        dtx <= 33'(req.target_x) - 33'(prev_x);
        dty <= 33'(req.target_y) - 33'(prev_y);
        ax  <= 33'(prev_x) - 33'(req.follower_x);
        ay  <= 33'(prev_y) - 33'(req.follower_y);
        bx  <= 33'(req.target_x) - 33'(req.follower_x);
        by  <= 33'(req.target_y) - 33'(req.follower_y);
      end
      ST_MAG: begin
        mtx   <= mag33(dtx);
        mty   <= mag33(dty);
        m0    <= mag33(ax);
        m1    <= mag33(ay);
        m2    <= mag33(bx);
        m3    <= mag33(by);
        neg0  <= ax[32];
        neg1  <= ay[32];
        neg2  <= bx[32];
        neg3  <= by[32];
        fwd   <= !dtx[32];
        degen <= (ax == '0 && ay == '0) || (bx == '0 && by == '0);
        yaw_zero <= (ax == '0 && ay == '0) || (bx == '0 && by == '0);
      end
      ST_HALF: begin
        big <= (m0 > HALF_LIMIT) || (m1 > HALF_LIMIT) ||
               (m2 > HALF_LIMIT) || (m3 > HALF_LIMIT);
      end
      ST_T_SQ1: begin
        // Large operands are halved (rounding up) so sums of two products stay in 64 bits.
        if (big) begin
          m0 <= 32'(({1'b0, m0} + 33'd1) >> 1);
          m1 <= 32'(({1'b0, m1} + 33'd1) >> 1);
          m2 <= 32'(({1'b0, m2} + 33'd1) >> 1);
          m3 <= 32'(({1'b0, m3} + 33'd1) >> 1);
        end
      end
      ST_T_SQ2, ST_A_SQ2, ST_B_SQ2: acc <= prod;
      ST_T_ROOT: begin
        if (sq_done) travel <= sq_root[32] ? 32'hFFFF_FFFF : sq_root[31:0];
      end
      ST_A_ROOT: begin
        if (sq_done) len_a <= sq_root[31:0];
      end
      ST_B_ROOT: begin
        if (sq_done) len_b <= sq_root[31:0];
      end
      ST_N_P2: p1 <= prod;
      ST_N_P3: p2 <= prod;
      ST_N_COMB: begin
        den <= prod;
        if ((neg0 ^ neg2) == (neg1 ^ neg3)) begin
          num     <= p1 + p2;
          num_neg <= neg0 ^ neg2;
        end else if (p1 >= p2) begin
          num     <= p1 - p2;
          num_neg <= neg0 ^ neg2;
        end else begin
          num     <= p2 - p1;
          num_neg <= neg1 ^ neg3;
        end
      end
      ST_N_DEC: begin
        if (den == '0) yaw_zero <= 1'b1;
        else if (num >= den) ratio <= RATIO_ONE;
      end
      ST_DIV_WAIT: begin
        if (div_done) ratio <= 31'(div_q);
      end
      ST_POST: begin
        logic [31:0] zc;
        zc = cord_z[33] ? 32'd0 :
             (cord_z > 34'(PI_Q30)) ? PI_Q30 : cord_z[31:0];
        zpost <= (num_neg && num != '0) ? PI_Q30 - zc : zc;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_data.travelled_distance <= travel;
          out_data.degenerate         <= degen;
          if (yaw_zero) out_data.turn_rate <= '0;
          else if (fwd) out_data.turn_rate <= -$signed(yclamp);
          else out_data.turn_rate <= $signed(yclamp);
        end
      end
      default: ;
    endcase
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |-> out_data.turn_rate == '0)
    else $error("degenerate result with nonzero yaw");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.turn_rate <= $signed(YAW_MAX)) &&
                  (out_data.turn_rate >= -$signed(YAW_MAX)))
    else $error("yaw out of range");

  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result loaded outside finish");

  a_first_no_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK && !initialized |=> state == ST_IDLE && initialized)
    else $error("first request not handled as store only");

endmodule

@@ rtl/core/lcyt_mul.sv @@
// ----------------------------------------------------------------------------
// lcyt_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module lcyt_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end
endmodule

@@ rtl/core/lcyt_sqrt.sv @@
// ----------------------------------------------------------------------------
// lcyt_sqrt
// Floor square root of a 66-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module lcyt_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [65:0] op,
  output logic [32:0] root,
  output logic        done
);
  logic [65:0] opnd;
  logic [35:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        take;

  always_comb begin
    rem_sh = {rem[33:0], opnd[65:64]};
    trial  = {1'b0, root, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd32) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd <= op;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      opnd <= {opnd[63:0], 2'b00};
      cnt  <= cnt + 6'd1;
      if (take) begin
        rem  <= rem_sh - trial;
        root <= {root[31:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[31:0], 1'b0};
      end
    end
  end
endmodule

@@ rtl/core/lcyt_div.sv @@
// ----------------------------------------------------------------------------
// lcyt_div
// Restoring divider giving a 30-bit fraction num/den for num below den.
// ----------------------------------------------------------------------------
module lcyt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [29:0] quo,
  output logic        done
);
  logic [64:0] r;
  logic [63:0] dreg;
  logic [4:0]  cnt;
  logic        busy;
  logic [64:0] r_sh;
  logic        take;

  always_comb begin
    r_sh = {r[63:0], 1'b0};
    take = r_sh >= {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd29) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r    <= {1'b0, num};
      dreg <= den;
      quo  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (take) begin
        r   <= r_sh - {1'b0, dreg};
        quo <= {quo[28:0], 1'b1};
      end else begin
        r   <= r_sh;
        quo <= {quo[28:0], 1'b0};
      end
    end
  end
endmodule

@@ rtl/core/lcyt_cordic.sv @@
// ----------------------------------------------------------------------------
// lcyt_cordic
// Vectoring CORDIC: angle of (x, y) in Q.30, one rotation per cycle.
// ----------------------------------------------------------------------------
module lcyt_cordic #(
  parameter int ITER = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [30:0]        x0,
  input  logic [30:0]        y0,
  output logic signed [33:0] z,
  output logic               done
);
  import lcyt_pkg::*;

  localparam int IW = $clog2(ITER);

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic [IW-1:0]      i;
  logic               busy;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic               ypos;

  always_comb begin
    xs   = x >>> i;
    ys   = y >>> i;
    at   = 34'(ATAN_Q30[5'(i)]);
    ypos = !y[33] && (y != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && i == IW'(ITER - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= 34'(x0);
      y <= 34'(y0);
      z <= '0;
      i <= '0;
    end else if (busy) begin
      i <= i + IW'(1);
      if (ypos) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end
    end
  end
endmodule
